// ===== rtl/rlaf_pkg.sv =====
`timescale 1ns / 1ps

package rlaf_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_MAX       = 2'd0,
        CFG_ARM_THROTTLE_LIMIT = 2'd1,
        CFG_ARM_TILT_LIMIT     = 2'd2,
        CFG_LOST_LIMIT         = 2'd3
    } cfg_sel_t;

    localparam logic [14:0] THROTTLE_MAX_RST       = 15'd1000;
    localparam logic [14:0] ARM_THROTTLE_LIMIT_RST = 15'd100;
    localparam logic [14:0] ARM_TILT_LIMIT_RST     = 15'd1000;
    localparam logic [15:0] LOST_LIMIT_RST         = 16'd100;

    localparam logic signed [16:0] THROTTLE_OFFSET = 17'sd1000;
    localparam logic [15:0]        MISS_MAX        = 16'hFFFF;

    // command bit positions
    localparam int CMD_ACC_CAL  = 0;
    localparam int CMD_GYRO_CAL = 1;
    localparam int CMD_ARM      = 2;
    localparam int CMD_REPLY    = 3;
    localparam int CMD_MAG_CAL  = 4;
    localparam int CMD_HOLD     = 5;

    // sensor status bit positions
    localparam int ST_BARO_OK   = 0;
    localparam int ST_BATT_LOW  = 1;
    localparam int ST_TAKEOFF   = 2;
    localparam int ST_THROW     = 3;
    localparam int ST_REPLY_ACK = 4;

    typedef struct packed {
        logic [14:0] throttle_max;
        logic [14:0] arm_throttle_limit;
        logic [14:0] arm_tilt_limit;
        logic [15:0] lost_limit;
    } cfg_t;

    typedef struct packed {
        logic               packet_valid;
        logic [15:0]        pitch_cmd_in;
        logic [15:0]        roll_cmd_in;
        logic [15:0]        yaw_cmd_in;
        logic [15:0]        throttle_raw;
        logic [7:0]         command_bits;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic [4:0]         sensor_status;
        logic signed [31:0] altitude_now;
    } item_t;

    typedef struct packed {
        logic [15:0]        pitch;
        logic [15:0]        roll;
        logic [15:0]        yaw;
        logic [14:0]        level;
        logic               lock;
        logic               hold;
        logic signed [31:0] hold_alt;
        logic               reply;
        logic               throw_on;
        logic [15:0]        miss;
    } state_t;

    // link state after reset: everything clear, lock set
    localparam state_t STATE_RST = '{
        pitch:    16'd0,
        roll:     16'd0,
        yaw:      16'd0,
        level:    15'd0,
        lock:     1'b1,
        hold:     1'b0,
        hold_alt: 32'sd0,
        reply:    1'b0,
        throw_on: 1'b0,
        miss:     16'd0
    };

    typedef struct packed {
        logic [15:0]        pitch_cmd;
        logic [15:0]        roll_cmd;
        logic [15:0]        yaw_cmd;
        logic [14:0]        throttle_out;
        logic               locked;
        logic               altitude_hold;
        logic signed [31:0] hold_target;
        logic               request_reply;
        logic               start_acc_cal;
        logic               start_gyro_cal;
        logic               start_mag_cal;
        logic               throw_mode;
    } result_t;

endpackage

// ===== rtl/rlaf_cfg.sv =====
`timescale 1ns / 1ps

module rlaf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rlaf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlaf_pkg::CFG_DATA_W-1:0] cfg_data,
    output rlaf_pkg::cfg_t                  cfg
);
    import rlaf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_sel_t'(cfg_index))
                CFG_THROTTLE_MAX:       cfg_next.throttle_max       = cfg_data[14:0];
                CFG_ARM_THROTTLE_LIMIT: cfg_next.arm_throttle_limit = cfg_data[14:0];
                CFG_ARM_TILT_LIMIT:     cfg_next.arm_tilt_limit     = cfg_data[14:0];
                CFG_LOST_LIMIT:         cfg_next.lost_limit         = cfg_data[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_max       <= THROTTLE_MAX_RST;
            cfg_reg.arm_throttle_limit <= ARM_THROTTLE_LIMIT_RST;
            cfg_reg.arm_tilt_limit     <= ARM_TILT_LIMIT_RST;
            cfg_reg.lost_limit         <= LOST_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rlaf_step.sv =====
`timescale 1ns / 1ps

module rlaf_step (
    input  rlaf_pkg::item_t   item,
    input  rlaf_pkg::state_t  state,
    input  rlaf_pkg::cfg_t    cfg,
    output rlaf_pkg::state_t  state_next,
    output rlaf_pkg::result_t res
);
    import rlaf_pkg::*;

    logic               reply_eff;
    logic               throw_eff;
    logic               throw_exit;
    logic               was_locked;
    logic signed [16:0] thr;
    logic signed [16:0] lvl;
    logic [14:0]        lvl_clamped;
    logic signed [16:0] pitch_ext;
    logic signed [16:0] roll_ext;
    logic [16:0]        pitch_mag;
    logic [16:0]        roll_mag;
    logic [15:0]        miss_inc;
    logic               arm_ok;
    logic               acc;
    logic               gyr;
    logic               mag;

    always_comb
    begin
        state_next = state;
        acc        = 1'b0;
        gyr        = 1'b0;
        mag        = 1'b0;
        throw_exit = 1'b0;

        // status acks act before the poll
        reply_eff  = state.reply & ~item.sensor_status[ST_REPLY_ACK];
        throw_eff  = state.throw_on | item.sensor_status[ST_THROW];
        state_next.reply    = reply_eff;
        state_next.throw_on = throw_eff;
        was_locked = state.lock;

        thr = {item.throttle_raw[15], item.throttle_raw} - THROTTLE_OFFSET;
        lvl = signed'({2'b00, state.level});

        pitch_ext = {item.pitch_angle[15], item.pitch_angle};
        roll_ext  = {item.roll_angle[15], item.roll_angle};
        pitch_mag = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);
        roll_mag  = roll_ext[16] ? 17'(-roll_ext) : 17'(roll_ext);

        miss_inc = (state.miss != MISS_MAX) ? state.miss + 16'd1 : state.miss;

        if (!state.hold)
        begin
            if (throw_eff)
            begin
                if (thr > lvl)
                begin
                    throw_exit = 1'b1;
                end
            end
            else
            begin
                lvl = thr;
            end
        end

        if (lvl[16])
        begin
            lvl_clamped = '0;
        end
        else if (lvl[15:0] > {1'b0, cfg.throttle_max})
        begin
            lvl_clamped = cfg.throttle_max;
        end
        else
        begin
            lvl_clamped = lvl[14:0];
        end

        arm_ok = item.command_bits[CMD_ARM]
               && (pitch_mag < {2'b00, cfg.arm_tilt_limit})
               && (roll_mag < {2'b00, cfg.arm_tilt_limit})
               && (lvl_clamped < cfg.arm_throttle_limit)
               && item.sensor_status[ST_BARO_OK]
               && !item.sensor_status[ST_BATT_LOW];

        if (!reply_eff)
        begin
            if (item.packet_valid)
            begin
                state_next.pitch = item.pitch_cmd_in;
                state_next.roll  = item.roll_cmd_in;
                state_next.yaw   = item.yaw_cmd_in;
                state_next.level = lvl_clamped;
                if (throw_exit)
                begin
                    state_next.throw_on = 1'b0;
                end
                if (item.command_bits[CMD_REPLY])
                begin
                    state_next.reply = 1'b1;
                end
                if (was_locked)
                begin
                    acc = item.command_bits[CMD_ACC_CAL];
                    gyr = item.command_bits[CMD_GYRO_CAL];
                    mag = item.command_bits[CMD_MAG_CAL];
                end
                if (arm_ok)
                begin
                    state_next.lock = 1'b0;
                end
                if (item.command_bits[CMD_HOLD] && !state_next.lock
                    && item.sensor_status[ST_TAKEOFF])
                begin
                    state_next.hold = !state.hold;
                    if (!state.hold)
                    begin
                        state_next.hold_alt = item.altitude_now;
                    end
                end
                state_next.miss = '0;
            end
            else
            begin
                state_next.miss = miss_inc;
                if (miss_inc >= cfg.lost_limit)
                begin
                    state_next.lock = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res.pitch_cmd      = state_next.pitch;
        res.roll_cmd       = state_next.roll;
        res.yaw_cmd        = state_next.yaw;
        res.throttle_out   = state_next.level;
        res.locked         = state_next.lock;
        res.altitude_hold  = state_next.hold;
        res.hold_target    = state_next.hold_alt;
        res.request_reply  = state_next.reply;
        res.start_acc_cal  = acc;
        res.start_gyro_cal = gyr;
        res.start_mag_cal  = mag;
        res.throw_mode     = state_next.throw_on;
    end

endmodule

// ===== rtl/rc_link_arming_failsafe_unit.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// input     | in        | in_valid/in_stall  | packet_valid .. altitude_now, one poll
// result    | out       | out_valid/out_stall| pitch_cmd .. throw_mode, one per poll
// config    | in        | cfg_we             | cfg_index, cfg_data
//
// one poll per cycle sustained while out_stall is low; a poll passes through the input
// register, then the step logic into the result register
// link state updates when a poll moves into the result register
// reset: stick/level/counter state cleared, lock set, config at defaults
// out_stall holds the result register; the input register still takes one more poll
// in_stall rises only when both registers are full and the result is stalled

module rc_link_arming_failsafe_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            packet_valid,
    input  logic [15:0]                     pitch_cmd_in,
    input  logic [15:0]                     roll_cmd_in,
    input  logic [15:0]                     yaw_cmd_in,
    input  logic [15:0]                     throttle_raw,
    input  logic [7:0]                      command_bits,
    input  logic signed [15:0]              pitch_angle,
    input  logic signed [15:0]              roll_angle,
    input  logic [4:0]                      sensor_status,
    input  logic signed [31:0]              altitude_now,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     pitch_cmd,
    output logic [15:0]                     roll_cmd,
    output logic [15:0]                     yaw_cmd,
    output logic [14:0]                     throttle_out,
    output logic                            locked,
    output logic                            altitude_hold,
    output logic signed [31:0]              hold_target,
    output logic                            request_reply,
    output logic                            start_acc_cal,
    output logic                            start_gyro_cal,
    output logic                            start_mag_cal,
    output logic                            throw_mode,

    input  logic                            cfg_we,
    input  logic [rlaf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlaf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rlaf_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t step_res;
    state_t  state_reg;
    state_t  state_next;
    logic    in_xfer;
    logic    move;

    rlaf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlaf_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .res        (step_res)
    );

    always_comb
    begin
        in_item.packet_valid  = packet_valid;
        in_item.pitch_cmd_in  = pitch_cmd_in;
        in_item.roll_cmd_in   = roll_cmd_in;
        in_item.yaw_cmd_in    = yaw_cmd_in;
        in_item.throttle_raw  = throttle_raw;
        in_item.command_bits  = command_bits;
        in_item.pitch_angle   = pitch_angle;
        in_item.roll_angle    = roll_angle;
        in_item.sensor_status = sensor_status;
        in_item.altitude_now  = altitude_now;
    end

    assign move     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !move;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= in_item;
        end
        if (move)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pitch_cmd      = out_res_reg.pitch_cmd;
    assign roll_cmd       = out_res_reg.roll_cmd;
    assign yaw_cmd        = out_res_reg.yaw_cmd;
    assign throttle_out   = out_res_reg.throttle_out;
    assign locked         = out_res_reg.locked;
    assign altitude_hold  = out_res_reg.altitude_hold;
    assign hold_target    = out_res_reg.hold_target;
    assign request_reply  = out_res_reg.request_reply;
    assign start_acc_cal  = out_res_reg.start_acc_cal;
    assign start_gyro_cal = out_res_reg.start_gyro_cal;
    assign start_mag_cal  = out_res_reg.start_mag_cal;
    assign throw_mode     = out_res_reg.throw_mode;

`ifndef NO_ASSERTIONS
    // input side only backs up when a poll is already parked
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stall without a parked poll");

    // a poll moving forward always shows up as a result
    a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("poll moved but no result registered");

    // link state only changes when a poll is evaluated
    a_state_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(state_reg))
        else $error("link state changed without a poll");

    // altitude hold can only switch on while unlocked
    a_hold_needs_unlock: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.hold) |-> !state_reg.lock)
        else $error("altitude hold engaged while locked");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import rlaf_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    localparam logic [7:0] M_ACC   = 8'd1 << CMD_ACC_CAL;
    localparam logic [7:0] M_GYRO  = 8'd1 << CMD_GYRO_CAL;
    localparam logic [7:0] M_ARM   = 8'd1 << CMD_ARM;
    localparam logic [7:0] M_REPLY = 8'd1 << CMD_REPLY;
    localparam logic [7:0] M_MAG   = 8'd1 << CMD_MAG_CAL;
    localparam logic [7:0] M_HOLD  = 8'd1 << CMD_HOLD;
    localparam logic [7:0] M_SPARE = 8'hC0;

    localparam logic [4:0] S_BARO    = 5'd1 << ST_BARO_OK;
    localparam logic [4:0] S_BATT    = 5'd1 << ST_BATT_LOW;
    localparam logic [4:0] S_TAKEOFF = 5'd1 << ST_TAKEOFF;
    localparam logic [4:0] S_THROW   = 5'd1 << ST_THROW;
    localparam logic [4:0] S_ACK     = 5'd1 << ST_REPLY_ACK;

    typedef enum logic [1:0] {
        POLL_NOISE,
        POLL_ARM,
        POLL_FLY,
        POLL_MISS
    } poll_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    item_t                 drv_poll = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [15:0]        pitch_cmd;
    logic [15:0]        roll_cmd;
    logic [15:0]        yaw_cmd;
    logic [14:0]        throttle_out;
    logic               locked;
    logic               altitude_hold;
    logic signed [31:0] hold_target;
    logic               request_reply;
    logic               start_acc_cal;
    logic               start_gyro_cal;
    logic               start_mag_cal;
    logic               throw_mode;

    // predicted link state and register copy
    logic [14:0] m_tmax;
    logic [14:0] m_arm_thr;
    logic [14:0] m_tilt;
    logic [15:0] m_lost;
    logic [15:0] m_pitch;
    logic [15:0] m_roll;
    logic [15:0] m_yaw;
    logic [15:0] m_level;
    logic        m_lock;
    logic        m_hold;
    logic [31:0] m_alt;
    logic        m_reply;
    logic        m_throw;
    logic [15:0] m_miss;

    item_t   poll_q[$];
    result_t expected_q[$];
    item_t   cur_poll;
    bit      busy = 1'b0;
    bit      moved;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      quiet_cycles = 0;
    int      err_cnt = 0;
    int      polls_sent = 0;
    int      polls_evaluated = 0;
    int      results_checked = 0;

    always #1 clk = ~clk;

    rc_link_arming_failsafe_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packet_valid   (drv_poll.packet_valid),
        .pitch_cmd_in   (drv_poll.pitch_cmd_in),
        .roll_cmd_in    (drv_poll.roll_cmd_in),
        .yaw_cmd_in     (drv_poll.yaw_cmd_in),
        .throttle_raw   (drv_poll.throttle_raw),
        .command_bits   (drv_poll.command_bits),
        .pitch_angle    (drv_poll.pitch_angle),
        .roll_angle     (drv_poll.roll_angle),
        .sensor_status  (drv_poll.sensor_status),
        .altitude_now   (drv_poll.altitude_now),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pitch_cmd      (pitch_cmd),
        .roll_cmd       (roll_cmd),
        .yaw_cmd        (yaw_cmd),
        .throttle_out   (throttle_out),
        .locked         (locked),
        .altitude_hold  (altitude_hold),
        .hold_target    (hold_target),
        .request_reply  (request_reply),
        .start_acc_cal  (start_acc_cal),
        .start_gyro_cal (start_gyro_cal),
        .start_mag_cal  (start_mag_cal),
        .throw_mode     (throw_mode),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    task automatic log_error(string msg);
        err_cnt++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic result_t predict_poll(item_t p);
        result_t            r;
        int                 thr;
        int                 lvl;
        int                 pmag;
        int                 rmag;
        logic signed [15:0] raw_s;
        logic signed [15:0] pa_s;
        logic signed [15:0] ra_s;
        logic               was_locked;
        logic [7:0]         cmd;
        logic [4:0]         st;
        r = '0;
        cmd = p.command_bits;
        st = p.sensor_status;
        if (st[ST_REPLY_ACK])
            m_reply = 1'b0;
        if (st[ST_THROW])
            m_throw = 1'b1;
        if (!m_reply)
        begin
            polls_evaluated++;
            if (p.packet_valid)
            begin
                was_locked = m_lock;
                raw_s = p.throttle_raw;
                pa_s = p.pitch_angle;
                ra_s = p.roll_angle;
                thr = int'(raw_s) - 1000;
                lvl = int'(m_level);
                pmag = (pa_s < 0) ? -int'(pa_s) : int'(pa_s);
                rmag = (ra_s < 0) ? -int'(ra_s) : int'(ra_s);
                m_pitch = p.pitch_cmd_in;
                m_roll = p.roll_cmd_in;
                m_yaw = p.yaw_cmd_in;
                if (!m_hold)
                begin
                    if (m_throw)
                    begin
                        if (thr > lvl)
                            m_throw = 1'b0;
                    end
                    else
                        lvl = thr;
                end
                if (lvl < 0)
                    lvl = 0;
                if (lvl > int'(m_tmax))
                    lvl = int'(m_tmax);
                m_level = 16'(lvl);
                if (cmd[CMD_REPLY])
                    m_reply = 1'b1;
                if (was_locked)
                begin
                    r.start_acc_cal = cmd[CMD_ACC_CAL];
                    r.start_gyro_cal = cmd[CMD_GYRO_CAL];
                    r.start_mag_cal = cmd[CMD_MAG_CAL];
                end
                if (cmd[CMD_ARM] && pmag < int'(m_tilt) && rmag < int'(m_tilt) &&
                    int'(m_level) < int'(m_arm_thr) && st[ST_BARO_OK] && !st[ST_BATT_LOW])
                    m_lock = 1'b0;
                if (cmd[CMD_HOLD] && !m_lock && st[ST_TAKEOFF])
                begin
                    m_hold = !m_hold;
                    if (m_hold)
                        m_alt = p.altitude_now;
                end
                m_miss = '0;
            end
            else
            begin
                if (m_miss != MISS_MAX)
                    m_miss++;
                if (m_miss >= m_lost)
                    m_lock = 1'b1;
            end
        end
        r.pitch_cmd = m_pitch;
        r.roll_cmd = m_roll;
        r.yaw_cmd = m_yaw;
        r.throttle_out = m_level[14:0];
        r.locked = m_lock;
        r.altitude_hold = m_hold;
        r.hold_target = m_alt;
        r.request_reply = m_reply;
        r.throw_mode = m_throw;
        return r;
    endfunction

    task automatic check_result(result_t got, result_t want);
        if (got.pitch_cmd !== want.pitch_cmd)
            log_error($sformatf("pitch_cmd %h, want %h", got.pitch_cmd, want.pitch_cmd));
        if (got.roll_cmd !== want.roll_cmd)
            log_error($sformatf("roll_cmd %h, want %h", got.roll_cmd, want.roll_cmd));
        if (got.yaw_cmd !== want.yaw_cmd)
            log_error($sformatf("yaw_cmd %h, want %h", got.yaw_cmd, want.yaw_cmd));
        if (got.throttle_out !== want.throttle_out)
            log_error($sformatf("throttle_out %0d, want %0d", got.throttle_out,
                                want.throttle_out));
        if (got.locked !== want.locked)
            log_error($sformatf("locked %b, want %b", got.locked, want.locked));
        if (got.altitude_hold !== want.altitude_hold)
            log_error($sformatf("altitude_hold %b, want %b", got.altitude_hold,
                                want.altitude_hold));
        if (got.hold_target !== want.hold_target)
            log_error($sformatf("hold_target %h, want %h", got.hold_target, want.hold_target));
        if (got.request_reply !== want.request_reply)
            log_error($sformatf("request_reply %b, want %b", got.request_reply,
                                want.request_reply));
        if (got.start_acc_cal !== want.start_acc_cal)
            log_error($sformatf("start_acc_cal %b, want %b", got.start_acc_cal,
                                want.start_acc_cal));
        if (got.start_gyro_cal !== want.start_gyro_cal)
            log_error($sformatf("start_gyro_cal %b, want %b", got.start_gyro_cal,
                                want.start_gyro_cal));
        if (got.start_mag_cal !== want.start_mag_cal)
            log_error($sformatf("start_mag_cal %b, want %b", got.start_mag_cal,
                                want.start_mag_cal));
        if (got.throw_mode !== want.throw_mode)
            log_error($sformatf("throw_mode %b, want %b", got.throw_mode, want.throw_mode));
    endtask

    function automatic item_t make_poll(logic v, logic [15:0] raw, logic [7:0] cmd,
                                        int pa, int ra, logic [4:0] st, logic [31:0] alt);
        item_t p;
        p.packet_valid = v;
        p.pitch_cmd_in = 16'($urandom);
        p.roll_cmd_in = 16'($urandom);
        p.yaw_cmd_in = 16'($urandom);
        p.throttle_raw = raw;
        p.command_bits = cmd;
        p.pitch_angle = 16'(pa);
        p.roll_angle = 16'(ra);
        p.sensor_status = st;
        p.altitude_now = alt;
        return p;
    endfunction

    function automatic item_t gen_poll(poll_kind_t kind);
        item_t      p;
        int         lim;
        int         pa;
        int         ra;
        logic [7:0] cmd;
        logic [4:0] st;
        pa = int'($urandom_range(36000)) - 18000;
        ra = int'($urandom_range(36000)) - 18000;
        cmd = 8'($urandom) & ~(M_ARM | M_REPLY | M_HOLD);
        st = 5'($urandom) & ~S_THROW;
        if ($urandom_range(99) < 5)
            st = st | S_THROW;
        if ($urandom_range(99) < 8)
            cmd = cmd | M_REPLY;
        p = make_poll(1'b1, 16'(1000 + $urandom_range(2500)), 8'h00, 0, 0, 5'd0, $urandom);
        case (kind)
            POLL_ARM:
            begin
                lim = (m_tilt > 15'd18000) ? 18000 : int'(m_tilt);
                pa = int'($urandom_range(2 * lim + 40)) - lim - 20;
                ra = int'($urandom_range(2 * lim + 40)) - lim - 20;
                if (pa > 18000) pa = 18000;
                if (pa < -18000) pa = -18000;
                if (ra > 18000) ra = 18000;
                if (ra < -18000) ra = -18000;
                p.throttle_raw = 16'(1000 + $urandom_range(int'(m_arm_thr) + 20));
                cmd = cmd | M_ARM;
                if ($urandom_range(99) < 20)
                    cmd = cmd | M_HOLD;
                st[ST_BARO_OK] = ($urandom_range(99) < 90);
                st[ST_BATT_LOW] = ($urandom_range(99) < 10);
            end
            POLL_FLY:
            begin
                if ($urandom_range(99) < 20)
                    cmd = cmd | M_HOLD;
                if ($urandom_range(99) < 10)
                    cmd = cmd | M_ARM;
                if ($urandom_range(99) < 10)
                    p.throttle_raw = 16'($urandom);
                st[ST_TAKEOFF] = ($urandom_range(99) < 70);
            end
            POLL_MISS:
                p.packet_valid = 1'b0;
            default:
            begin
                p.packet_valid = 1'($urandom);
                p.throttle_raw = 16'($urandom);
                cmd = 8'($urandom);
                st = 5'($urandom);
            end
        endcase
        p.pitch_angle = 16'(pa);
        p.roll_angle = 16'(ra);
        p.command_bits = cmd;
        p.sensor_status = st;
        return p;
    endfunction

    task automatic write_reg(cfg_sel_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_THROTTLE_MAX:       m_tmax = val[14:0];
            CFG_ARM_THROTTLE_LIMIT: m_arm_thr = val[14:0];
            CFG_ARM_TILT_LIMIT:     m_tilt = val[14:0];
            default:                m_lost = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] tmax, logic [15:0] arm_thr, logic [15:0] tilt,
                              logic [15:0] lost);
        write_reg(CFG_THROTTLE_MAX, tmax);
        write_reg(CFG_ARM_THROTTLE_LIMIT, arm_thr);
        write_reg(CFG_ARM_TILT_LIMIT, tilt);
        write_reg(CFG_LOST_LIMIT, lost);
    endtask

    task automatic drain;
        while (poll_q.size() != 0 || expected_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall, int target);
        int         start;
        int         sel;
        int         n;
        int         miss_max;
        poll_kind_t kind;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        start = polls_evaluated;
        miss_max = (m_lost < 16'd38) ? int'(m_lost) + 2 : 40;
        while (polls_evaluated - start < target)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
            begin
                kind = POLL_ARM;
                n = $urandom_range(1, 3);
            end
            else if (sel < 65)
            begin
                kind = POLL_FLY;
                n = $urandom_range(3, 15);
            end
            else if (sel < 85)
            begin
                kind = POLL_MISS;
                n = $urandom_range(1, miss_max);
            end
            else
            begin
                kind = POLL_NOISE;
                n = $urandom_range(1, 4);
            end
            repeat (n) poll_q.push_back(gen_poll(kind));
            while (poll_q.size() > 8)
                @(posedge clk);
        end
        drain();
    endtask

    // driver: new poll at the falling edge once the previous one has transferred
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!busy)
        begin
            if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_poll = poll_q[0];
                busy = 1'b1;
                drv_poll <= cur_poll;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // monitor: input transfers feed the predictor, result transfers are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(predict_poll(cur_poll));
                void'(poll_q.pop_front());
                busy = 1'b0;
                polls_sent++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                    log_error("result transfer with no poll outstanding");
                else
                begin
                    check_result({pitch_cmd, roll_cmd, yaw_cmd, throttle_out, locked,
                                  altitude_hold, hold_target, request_reply, start_acc_cal,
                                  start_gyro_cal, start_mag_cal, throw_mode},
                                 expected_q.pop_front());
                    results_checked++;
                end
            end
            if (moved || (poll_q.size() == 0 && expected_q.size() == 0 && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("transfers stopped for %0d cycles", QUIET_LIMIT);
        $display("** rc_link_arming_failsafe_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        m_tmax = THROTTLE_MAX_RST;
        m_arm_thr = ARM_THROTTLE_LIMIT_RST;
        m_tilt = ARM_TILT_LIMIT_RST;
        m_lost = LOST_LIMIT_RST;
        m_pitch = '0;
        m_roll = '0;
        m_yaw = '0;
        m_level = '0;
        m_lock = 1'b1;
        m_hold = 1'b0;
        m_alt = '0;
        m_reply = 1'b0;
        m_throw = 1'b0;
        m_miss = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed polls at reset config
        poll_q.push_back(make_poll(1'b0, 16'd0, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q[0].pitch_cmd_in = 16'hFFFF;
        poll_q[0].roll_cmd_in = 16'hFFFF;
        poll_q[0].yaw_cmd_in = 16'hFFFF;
        poll_q.push_back(make_poll(1'b1, 16'd0, M_ACC | M_GYRO | M_MAG, 18000, -18000,
                                   5'd0, 32'd0));
        poll_q[1].pitch_cmd_in = 16'h0000;
        poll_q[1].roll_cmd_in = 16'h0000;
        poll_q[1].yaw_cmd_in = 16'h0000;
        poll_q.push_back(make_poll(1'b1, 16'hFFFF, 8'h00, -18000, 18000, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'h7FFF, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'h8000, 8'h00, 0, 0, 5'd0, 32'd0));
        // arming refused: throttle, tilt at limit, battery alarm, baro not ready
        poll_q.push_back(make_poll(1'b1, 16'd1999, M_ARM, 0, 0, S_BARO, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1050, M_ARM, -1000, 0, S_BARO, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1050, M_ARM, 0, 999, S_BARO | S_BATT, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1050, M_ARM, 0, 0, 5'd0, 32'd0));
        // arm, calibrate and enter hold on the same transfer
        poll_q.push_back(make_poll(1'b1, 16'd1099, M_ARM | M_HOLD | M_ACC, -999, 999,
                                   S_BARO | S_TAKEOFF, 32'h7FFF_FFFF));
        poll_q.push_back(make_poll(1'b1, 16'd1500, M_ACC | M_GYRO | M_MAG | M_SPARE, 0, 0,
                                   5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1200, M_HOLD, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1300, M_HOLD, 0, 0, S_TAKEOFF, 32'h8000_0000));
        // reply pending ignores polls until acknowledged
        poll_q.push_back(make_poll(1'b1, 16'd1300, M_REPLY, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1600, M_ARM, 0, 0, S_BARO, 32'd0));
        poll_q.push_back(make_poll(1'b0, 16'd0, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1100, 8'h00, 0, 0, S_ACK, 32'd0));
        // throw mode holds the level until the stick rises above it
        poll_q.push_back(make_poll(1'b1, 16'd1050, 8'h00, 0, 0, S_THROW, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1100, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1101, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1101, 8'h00, 0, 0, 5'd0, 32'd0));
        poll_q.push_back(make_poll(1'b0, 16'd0, 8'h00, 0, 0, S_THROW | S_ACK, 32'd0));
        poll_q.push_back(make_poll(1'b1, 16'd1000, 8'h00, 18000, -18000, 5'd0, 32'd0));
        drain();

        set_config(16'h7FFF, 16'h7FFF, 16'd18000, 16'hFFFF);
        run_phase(0, 0, 460);
        set_config(16'($urandom_range(200, 4000)), 16'($urandom_range(20, 500)),
                   16'($urandom_range(300, 5000)), 16'($urandom_range(2, 30)));
        run_phase(81, 0, 460);
        set_config(16'd0, 16'd0, 16'd0, 16'd1);
        run_phase(0, 81, 460);
        set_config(16'($urandom_range(200, 4000)), 16'($urandom_range(20, 500)),
                   16'($urandom_range(300, 5000)), 16'($urandom_range(2, 30)));
        run_phase(9, 9, 460);

        repeat (20) @(posedge clk);
        if (expected_q.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_q.size()));
        $display("%0d polls transferred, %0d evaluated, %0d results checked, %0d errors",
                 polls_sent, polls_evaluated, results_checked, err_cnt);
        $display("config at reset, maximum, minimum and two random sets; idle and stall mixes");
        if (err_cnt == 0)
            $display("** rc_link_arming_failsafe_unit: PASSED **");
        else
            $display("** rc_link_arming_failsafe_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rlaf_pkg.sv
rtl/rlaf_cfg.sv
rtl/rlaf_step.sv
rtl/rc_link_arming_failsafe_unit.sv
sim/testbench.sv
